@@ hw/rtl/v3q_pkg.sv @@
package v3q_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int SUM_WIDTH  = DATA_WIDTH + 2;

    typedef logic signed [DATA_WIDTH-1:0] fx_word_t;
    typedef logic signed [PROD_WIDTH-1:0] fx_prod_t;
    typedef logic signed [SUM_WIDTH-1:0]  fx_sum_t;
    typedef fx_word_t [2:0]               fx_vec_t;

    localparam fx_word_t FX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam fx_word_t FX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef logic [2:0] op_t;

    localparam op_t OP_ADD   = 3'd0;
    localparam op_t OP_SUB   = 3'd1;
    localparam op_t OP_SCALE = 3'd2;
    localparam op_t OP_DOT   = 3'd3;
    localparam op_t OP_CROSS = 3'd4;
    localparam op_t OP_ROT   = 3'd5;

    // Saturated word with its overflow flag
    typedef struct packed {
        logic     ov;
        fx_word_t v;
    } fx_t;

    typedef struct packed {
        op_t      req_type;
        fx_word_t a_x;
        fx_word_t a_y;
        fx_word_t a_z;
        fx_word_t b_x;
        fx_word_t b_y;
        fx_word_t b_z;
        fx_word_t scalar_in;
    } req_t;

    typedef struct packed {
        fx_word_t r_x;
        fx_word_t r_y;
        fx_word_t r_z;
        fx_word_t scalar_out;
        logic     overflow;
    } rsp_t;

    // Front half to back half: rotate coefficients and finished simple results
    typedef struct packed {
        logic     valid;
        op_t      op;
        logic     ov;
        fx_vec_t  a;
        fx_vec_t  b;
        fx_vec_t  c;
        fx_word_t k1;
        fx_word_t k2;
        fx_word_t k3;
        fx_vec_t  simple;
        fx_word_t scal;
    } mid_t;

    // Back half to output stage: truncated rotate terms
    typedef struct packed {
        logic     valid;
        op_t      op;
        logic     ov;
        fx_vec_t  simple;
        fx_word_t scal;
        fx_vec_t  t1;
        fx_vec_t  t2;
        fx_vec_t  t3;
    } end_t;

    function automatic fx_prod_t fx_mul_full(fx_word_t x, fx_word_t y);
        return fx_prod_t'(x) * fx_prod_t'(y);
    endfunction

    // Shift the exact product down (floor) and clamp to a word
    function automatic fx_t fx_trunc(fx_prod_t p);
        fx_prod_t sh;
        fx_t      r;
        sh = p >>> FRAC_BITS;
        if (sh > fx_prod_t'(FX_MAX)) begin
            r.ov = 1'b1;
            r.v  = FX_MAX;
        end
        else if (sh < fx_prod_t'(FX_MIN)) begin
            r.ov = 1'b1;
            r.v  = FX_MIN;
        end
        else begin
            r.ov = 1'b0;
            r.v  = sh[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic fx_t fx_sat(fx_sum_t s);
        fx_t r;
        if (s > fx_sum_t'(FX_MAX)) begin
            r.ov = 1'b1;
            r.v  = FX_MAX;
        end
        else if (s < fx_sum_t'(FX_MIN)) begin
            r.ov = 1'b1;
            r.v  = FX_MIN;
        end
        else begin
            r.ov = 1'b0;
            r.v  = s[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic fx_t fx_add2(fx_word_t x, fx_word_t y);
        fx_sum_t xs;
        fx_sum_t ys;
        xs = fx_sum_t'(x);
        ys = fx_sum_t'(y);
        return fx_sat(xs + ys);
    endfunction

    function automatic fx_t fx_sub2(fx_word_t x, fx_word_t y);
        fx_sum_t xs;
        fx_sum_t ys;
        xs = fx_sum_t'(x);
        ys = fx_sum_t'(y);
        return fx_sat(xs - ys);
    endfunction

    function automatic fx_t fx_add3(fx_word_t x, fx_word_t y, fx_word_t z);
        fx_sum_t xs;
        fx_sum_t ys;
        fx_sum_t zs;
        xs = fx_sum_t'(x);
        ys = fx_sum_t'(y);
        zs = fx_sum_t'(z);
        return fx_sat(xs + ys + zs);
    endfunction

endpackage

@@ hw/rtl/v3q_front.sv @@
module v3q_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  v3q_pkg::req_t   req,
    output v3q_pkg::mid_t   mid
);

    // Stage 1: operands
    logic                v1_reg;
    v3q_pkg::op_t        op1_reg;
    v3q_pkg::fx_word_t   a1_reg [3];
    v3q_pkg::fx_word_t   b1_reg [3];
    v3q_pkg::fx_word_t   s1_reg;

    // Stage 2: exact products, add/sub
    logic                v2_reg;
    v3q_pkg::op_t        op2_reg;
    v3q_pkg::fx_prod_t   pab_reg [3];
    v3q_pkg::fx_prod_t   pbb_reg [3];
    v3q_pkg::fx_prod_t   pas_reg [3];
    v3q_pkg::fx_prod_t   pm_reg  [6];
    v3q_pkg::fx_prod_t   pss_reg;
    v3q_pkg::fx_t        sadd_reg [3];
    v3q_pkg::fx_t        ssub_reg [3];
    v3q_pkg::fx_t        k3_2_reg;
    v3q_pkg::fx_word_t   a2_reg [3];
    v3q_pkg::fx_word_t   b2_reg [3];

    // Stage 3: truncated products
    logic                v3_reg;
    v3q_pkg::op_t        op3_reg;
    logic                ov3_reg;
    v3q_pkg::fx_word_t   qab_reg [3];
    v3q_pkg::fx_word_t   qbb_reg [3];
    v3q_pkg::fx_word_t   qm_reg  [6];
    v3q_pkg::fx_word_t   qss_reg;
    v3q_pkg::fx_word_t   pre3_reg [3];
    v3q_pkg::fx_word_t   k3_3_reg;
    v3q_pkg::fx_word_t   a3_reg [3];
    v3q_pkg::fx_word_t   b3_reg [3];

    // Stage 4: dot sums and cross differences
    logic                v4_reg;
    v3q_pkg::op_t        op4_reg;
    logic                ov4_reg;
    v3q_pkg::fx_word_t   dab4_reg;
    v3q_pkg::fx_word_t   dbb4_reg;
    v3q_pkg::fx_word_t   qss4_reg;
    v3q_pkg::fx_word_t   c4_reg [3];
    v3q_pkg::fx_word_t   simple4_reg [3];
    v3q_pkg::fx_word_t   scal4_reg;
    v3q_pkg::fx_word_t   k3_4_reg;
    v3q_pkg::fx_word_t   a4_reg [3];
    v3q_pkg::fx_word_t   b4_reg [3];

    // Stage 5: rotate coefficients
    logic                v5_reg;
    v3q_pkg::op_t        op5_reg;
    logic                ov5_reg;
    v3q_pkg::fx_word_t   k1_5_reg;
    v3q_pkg::fx_word_t   k2_5_reg;
    v3q_pkg::fx_word_t   k3_5_reg;
    v3q_pkg::fx_word_t   c5_reg [3];
    v3q_pkg::fx_word_t   simple5_reg [3];
    v3q_pkg::fx_word_t   scal5_reg;
    v3q_pkg::fx_word_t   a5_reg [3];
    v3q_pkg::fx_word_t   b5_reg [3];

    v3q_pkg::fx_t        tab [3];
    v3q_pkg::fx_t        tbb [3];
    v3q_pkg::fx_t        tas [3];
    v3q_pkg::fx_t        tm  [6];
    v3q_pkg::fx_t        tss;
    v3q_pkg::fx_word_t   pre3_next [3];
    logic                ov3_next;

    v3q_pkg::fx_t        dab;
    v3q_pkg::fx_t        dbb;
    v3q_pkg::fx_t        c1 [3];
    v3q_pkg::fx_t        c2 [3];
    v3q_pkg::fx_word_t   simple4_next [3];
    v3q_pkg::fx_word_t   scal4_next;
    logic                ov4_next;

    v3q_pkg::fx_t        k1;
    v3q_pkg::fx_t        k2;
    logic                ov5_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg   <= req.req_type;
        a1_reg[0] <= req.a_x;
        a1_reg[1] <= req.a_y;
        a1_reg[2] <= req.a_z;
        b1_reg[0] <= req.b_x;
        b1_reg[1] <= req.b_y;
        b1_reg[2] <= req.b_z;
        s1_reg    <= req.scalar_in;
    end

    // Cross terms in pairs: (ay.bz, az.by), (az.bx, ax.bz), (ax.by, ay.bx)
    always_ff @(posedge clk)
    begin
        op2_reg <= op1_reg;
        for (int i = 0; i < 3; i++)
        begin
            pab_reg[i]  <= v3q_pkg::fx_mul_full(a1_reg[i], b1_reg[i]);
            pbb_reg[i]  <= v3q_pkg::fx_mul_full(b1_reg[i], b1_reg[i]);
            pas_reg[i]  <= v3q_pkg::fx_mul_full(a1_reg[i], s1_reg);
            sadd_reg[i] <= v3q_pkg::fx_add2(a1_reg[i], b1_reg[i]);
            ssub_reg[i] <= v3q_pkg::fx_sub2(a1_reg[i], b1_reg[i]);
            a2_reg[i]   <= a1_reg[i];
            b2_reg[i]   <= b1_reg[i];
        end
        pm_reg[0] <= v3q_pkg::fx_mul_full(a1_reg[1], b1_reg[2]);
        pm_reg[1] <= v3q_pkg::fx_mul_full(a1_reg[2], b1_reg[1]);
        pm_reg[2] <= v3q_pkg::fx_mul_full(a1_reg[2], b1_reg[0]);
        pm_reg[3] <= v3q_pkg::fx_mul_full(a1_reg[0], b1_reg[2]);
        pm_reg[4] <= v3q_pkg::fx_mul_full(a1_reg[0], b1_reg[1]);
        pm_reg[5] <= v3q_pkg::fx_mul_full(a1_reg[1], b1_reg[0]);
        pss_reg   <= v3q_pkg::fx_mul_full(s1_reg, s1_reg);
        k3_2_reg  <= v3q_pkg::fx_add2(s1_reg, s1_reg);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tab[i] = v3q_pkg::fx_trunc(pab_reg[i]);
            tbb[i] = v3q_pkg::fx_trunc(pbb_reg[i]);
            tas[i] = v3q_pkg::fx_trunc(pas_reg[i]);
        end
        for (int j = 0; j < 6; j++)
        begin
            tm[j] = v3q_pkg::fx_trunc(pm_reg[j]);
        end
        tss = v3q_pkg::fx_trunc(pss_reg);

        ov3_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            pre3_next[i] = '0;
        end
        case (op2_reg)
            v3q_pkg::OP_ADD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pre3_next[i] = sadd_reg[i].v;
                end
                ov3_next = sadd_reg[0].ov | sadd_reg[1].ov | sadd_reg[2].ov;
            end
            v3q_pkg::OP_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pre3_next[i] = ssub_reg[i].v;
                end
                ov3_next = ssub_reg[0].ov | ssub_reg[1].ov | ssub_reg[2].ov;
            end
            v3q_pkg::OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pre3_next[i] = tas[i].v;
                end
                ov3_next = tas[0].ov | tas[1].ov | tas[2].ov;
            end
            v3q_pkg::OP_DOT:
            begin
                ov3_next = tab[0].ov | tab[1].ov | tab[2].ov;
            end
            v3q_pkg::OP_CROSS:
            begin
                ov3_next = tm[0].ov | tm[1].ov | tm[2].ov
                         | tm[3].ov | tm[4].ov | tm[5].ov;
            end
            v3q_pkg::OP_ROT:
            begin
                ov3_next = tab[0].ov | tab[1].ov | tab[2].ov
                         | tbb[0].ov | tbb[1].ov | tbb[2].ov
                         | tm[0].ov | tm[1].ov | tm[2].ov
                         | tm[3].ov | tm[4].ov | tm[5].ov
                         | tss.ov | k3_2_reg.ov;
            end
            default:
            begin
                ov3_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op3_reg  <= op2_reg;
        ov3_reg  <= ov3_next;
        qss_reg  <= tss.v;
        k3_3_reg <= k3_2_reg.v;
        for (int i = 0; i < 3; i++)
        begin
            qab_reg[i]  <= tab[i].v;
            qbb_reg[i]  <= tbb[i].v;
            pre3_reg[i] <= pre3_next[i];
            a3_reg[i]   <= a2_reg[i];
            b3_reg[i]   <= b2_reg[i];
        end
        for (int j = 0; j < 6; j++)
        begin
            qm_reg[j] <= tm[j].v;
        end
    end

    // c1 is a x b, c2 is b x a: same products, opposite order of subtraction
    always_comb
    begin
        dab = v3q_pkg::fx_add3(qab_reg[0], qab_reg[1], qab_reg[2]);
        dbb = v3q_pkg::fx_add3(qbb_reg[0], qbb_reg[1], qbb_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            c1[i] = v3q_pkg::fx_sub2(qm_reg[2*i], qm_reg[2*i+1]);
            c2[i] = v3q_pkg::fx_sub2(qm_reg[2*i+1], qm_reg[2*i]);
            simple4_next[i] = pre3_reg[i];
        end
        scal4_next = '0;
        ov4_next   = ov3_reg;
        case (op3_reg)
            v3q_pkg::OP_DOT:
            begin
                scal4_next = dab.v;
                ov4_next   = ov3_reg | dab.ov;
            end
            v3q_pkg::OP_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    simple4_next[i] = c1[i].v;
                end
                ov4_next = ov3_reg | c1[0].ov | c1[1].ov | c1[2].ov;
            end
            v3q_pkg::OP_ROT:
            begin
                ov4_next = ov3_reg | dab.ov | dbb.ov
                         | c2[0].ov | c2[1].ov | c2[2].ov;
            end
            default:
            begin
                ov4_next = ov3_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op4_reg   <= op3_reg;
        ov4_reg   <= ov4_next;
        dab4_reg  <= dab.v;
        dbb4_reg  <= dbb.v;
        qss4_reg  <= qss_reg;
        scal4_reg <= scal4_next;
        k3_4_reg  <= k3_3_reg;
        for (int i = 0; i < 3; i++)
        begin
            c4_reg[i]      <= c2[i].v;
            simple4_reg[i] <= simple4_next[i];
            a4_reg[i]      <= a3_reg[i];
            b4_reg[i]      <= b3_reg[i];
        end
    end

    always_comb
    begin
        k1       = v3q_pkg::fx_add2(dab4_reg, dab4_reg);
        k2       = v3q_pkg::fx_sub2(qss4_reg, dbb4_reg);
        ov5_next = ov4_reg;
        if (op4_reg == v3q_pkg::OP_ROT)
        begin
            ov5_next = ov4_reg | k1.ov | k2.ov;
        end
    end

    always_ff @(posedge clk)
    begin
        op5_reg   <= op4_reg;
        ov5_reg   <= ov5_next;
        k1_5_reg  <= k1.v;
        k2_5_reg  <= k2.v;
        k3_5_reg  <= k3_4_reg;
        scal5_reg <= scal4_reg;
        for (int i = 0; i < 3; i++)
        begin
            c5_reg[i]      <= c4_reg[i];
            simple5_reg[i] <= simple4_reg[i];
            a5_reg[i]      <= a4_reg[i];
            b5_reg[i]      <= b4_reg[i];
        end
    end

    always_comb
    begin
        mid.valid = v5_reg;
        mid.op    = op5_reg;
        mid.ov    = ov5_reg;
        mid.k1    = k1_5_reg;
        mid.k2    = k2_5_reg;
        mid.k3    = k3_5_reg;
        mid.scal  = scal5_reg;
        for (int i = 0; i < 3; i++)
        begin
            mid.a[i]      = a5_reg[i];
            mid.b[i]      = b5_reg[i];
            mid.c[i]      = c5_reg[i];
            mid.simple[i] = simple5_reg[i];
        end
    end

endmodule

@@ hw/rtl/v3q_back.sv @@
module v3q_back (
    input  logic            clk,
    input  logic            rst_n,
    input  v3q_pkg::mid_t   mid,
    output v3q_pkg::end_t   ed
);

    // Stage 6: exact rotate products
    logic                v6_reg;
    v3q_pkg::op_t        op6_reg;
    logic                ov6_reg;
    v3q_pkg::fx_prod_t   pk1_reg [3];
    v3q_pkg::fx_prod_t   pk2_reg [3];
    v3q_pkg::fx_prod_t   pk3_reg [3];
    v3q_pkg::fx_word_t   simple6_reg [3];
    v3q_pkg::fx_word_t   scal6_reg;

    // Stage 7: truncated rotate terms
    logic                v7_reg;
    v3q_pkg::op_t        op7_reg;
    logic                ov7_reg;
    v3q_pkg::fx_word_t   t1_reg [3];
    v3q_pkg::fx_word_t   t2_reg [3];
    v3q_pkg::fx_word_t   t3_reg [3];
    v3q_pkg::fx_word_t   simple7_reg [3];
    v3q_pkg::fx_word_t   scal7_reg;

    v3q_pkg::fx_t        t1 [3];
    v3q_pkg::fx_t        t2 [3];
    v3q_pkg::fx_t        t3 [3];
    logic                ov7_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v6_reg <= mid.valid;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op6_reg   <= mid.op;
        ov6_reg   <= mid.ov;
        scal6_reg <= mid.scal;
        for (int i = 0; i < 3; i++)
        begin
            pk1_reg[i]     <= v3q_pkg::fx_mul_full(mid.b[i], mid.k1);
            pk2_reg[i]     <= v3q_pkg::fx_mul_full(mid.a[i], mid.k2);
            pk3_reg[i]     <= v3q_pkg::fx_mul_full(mid.c[i], mid.k3);
            simple6_reg[i] <= mid.simple[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t1[i] = v3q_pkg::fx_trunc(pk1_reg[i]);
            t2[i] = v3q_pkg::fx_trunc(pk2_reg[i]);
            t3[i] = v3q_pkg::fx_trunc(pk3_reg[i]);
        end
        ov7_next = ov6_reg;
        if (op6_reg == v3q_pkg::OP_ROT)
        begin
            ov7_next = ov6_reg
                     | t1[0].ov | t1[1].ov | t1[2].ov
                     | t2[0].ov | t2[1].ov | t2[2].ov
                     | t3[0].ov | t3[1].ov | t3[2].ov;
        end
    end

    always_ff @(posedge clk)
    begin
        op7_reg   <= op6_reg;
        ov7_reg   <= ov7_next;
        scal7_reg <= scal6_reg;
        for (int i = 0; i < 3; i++)
        begin
            t1_reg[i]      <= t1[i].v;
            t2_reg[i]      <= t2[i].v;
            t3_reg[i]      <= t3[i].v;
            simple7_reg[i] <= simple6_reg[i];
        end
    end

    always_comb
    begin
        ed.valid = v7_reg;
        ed.op    = op7_reg;
        ed.ov    = ov7_reg;
        ed.scal  = scal7_reg;
        for (int i = 0; i < 3; i++)
        begin
            ed.simple[i] = simple7_reg[i];
            ed.t1[i]     = t1_reg[i];
            ed.t2[i]     = t2_reg[i];
            ed.t3[i]     = t3_reg[i];
        end
    end

endmodule

@@ hw/rtl/vec3_alu_with_quaternion_rotate_core.sv @@
// Three-component vector unit, signed Q16.16: add, subtract, scale, dot, cross,
// and rotation of vector a by the quaternion (b, scalar_in).
// Request channel: drive req and raise start; the item is taken at any rising
// edge with start high and busy low. busy stays low, so an item may enter on
// every clock cycle.
// Result channel: done is high for exactly one cycle per item, with rsp valid
// in that same cycle. done is registered from the last pipeline stage, and results
// leave in the order the items came in.
// Throughput: one item per clock, set by the eight-stage multiply pipeline
// (two rounds of 32x32 products, each followed by truncation and summing).
// The receiver cannot stall: a result not taken in its done cycle is gone.
// Reset (rst_n low, asynchronous) clears every valid bit in the pipeline;
// items in flight are dropped and done stays low until new items arrive.
// Unknown operation codes give zero fields and no overflow.
module vec3_alu_with_quaternion_rotate_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  v3q_pkg::req_t   req,
    output logic            done,
    output v3q_pkg::rsp_t   rsp
);

    v3q_pkg::mid_t      mid;
    v3q_pkg::end_t      ed;

    logic               done_reg;
    v3q_pkg::rsp_t      rsp_reg;
    v3q_pkg::rsp_t      rsp_next;
    v3q_pkg::fx_t       rot [3];

    v3q_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .mid   (mid)
    );

    v3q_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .mid   (mid),
        .ed    (ed)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rot[i] = v3q_pkg::fx_add3(ed.t1[i], ed.t2[i], ed.t3[i]);
        end
        rsp_next.r_x        = ed.simple[0];
        rsp_next.r_y        = ed.simple[1];
        rsp_next.r_z        = ed.simple[2];
        rsp_next.scalar_out = ed.scal;
        rsp_next.overflow   = ed.ov;
        case (ed.op)
            v3q_pkg::OP_ROT:
            begin
                rsp_next.r_x      = rot[0].v;
                rsp_next.r_y      = rot[1].v;
                rsp_next.r_z      = rot[2].v;
                rsp_next.overflow = ed.ov | rot[0].ov | rot[1].ov | rot[2].ov;
            end
            default:
            begin
                rsp_next.overflow = ed.ov;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ed.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ed.valid |=> done)
        else $error("item in last stage produced no done strobe");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !ed.valid |=> !done)
        else $error("done strobe without an item in last stage");

    a_dot_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (ed.valid && ed.op == v3q_pkg::OP_DOT)
            |=> (rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0))
        else $error("dot result carries a non-zero vector");

    a_scalar_only_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (ed.valid && ed.op != v3q_pkg::OP_DOT) |=> (rsp.scalar_out == '0))
        else $error("scalar result non-zero outside dot");

endmodule

@@ tb/tb_vec3_alu_with_quaternion_rotate_core.sv @@
`timescale 1ns / 1ps

module tb_vec3_alu_with_quaternion_rotate_core;

    typedef v3q_pkg::op_t      op_t;
    typedef v3q_pkg::req_t     req_t;
    typedef v3q_pkg::rsp_t     rsp_t;
    typedef v3q_pkg::fx_word_t fx_word_t;

    localparam int       DATA_WIDTH = v3q_pkg::DATA_WIDTH;
    localparam int       FRAC_BITS  = v3q_pkg::FRAC_BITS;
    localparam fx_word_t FX_MAX     = v3q_pkg::FX_MAX;
    localparam fx_word_t FX_MIN     = v3q_pkg::FX_MIN;

    localparam op_t OP_ADD   = v3q_pkg::OP_ADD;
    localparam op_t OP_SUB   = v3q_pkg::OP_SUB;
    localparam op_t OP_SCALE = v3q_pkg::OP_SCALE;
    localparam op_t OP_DOT   = v3q_pkg::OP_DOT;
    localparam op_t OP_CROSS = v3q_pkg::OP_CROSS;
    localparam op_t OP_ROT   = v3q_pkg::OP_ROT;

    localparam int  RANDOM_ITEMS = 750;
    localparam int  DRAIN_CYCLES = 16;
    localparam int  STALL_LIMIT  = 400;
    localparam int  REPORT_MAX   = 10;

    localparam op_t OP_SPARE6 = 3'd6;
    localparam op_t OP_SPARE7 = 3'd7;

    localparam fx_word_t ONE        = 32'sh0001_0000;
    localparam fx_word_t HALF_SQRT2 = 32'sh0000_B505;
    localparam fx_word_t HALF       = 32'sh0000_8000;

    localparam longint WORD_MAX = longint'(FX_MAX);
    localparam longint WORD_MIN = longint'(FX_MIN);

    typedef struct {
        req_t q;
        bit   fixed_exp;
        rsp_t exp_rsp;
    } vec_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t req;
    rsp_t rsp;

    // Side channel telling the monitor what the current item should give
    bit   cur_fixed;
    rsp_t cur_exp;

    rsp_t     rsp_due[$];
    vec_row_t plan[$];
    int       n_taken  = 0;
    int       n_err    = 0;
    int       idle_cnt = 0;

    vec3_alu_with_quaternion_rotate_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------- fixed-point predictor ----------------

    function automatic longint sx(fx_word_t w);
        return longint'(w);
    endfunction

    function automatic longint clamp_word(longint v, inout bit ov);
        if (v > WORD_MAX)
        begin
            ov = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            ov = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    // Operands are always 32-bit values here, so the exact product fits in 64 bits
    function automatic longint qmul(longint x, longint y, inout bit ov);
        longint p;
        p = (x * y) >>> FRAC_BITS;
        return clamp_word(p, ov);
    endfunction

    function automatic longint dot3(input longint px, py, pz, qx, qy, qz,
                                    inout bit ov);
        return clamp_word(qmul(px, qx, ov) + qmul(py, qy, ov) + qmul(pz, qz, ov), ov);
    endfunction

    function automatic void cross3(input longint px, py, pz, qx, qy, qz,
                                   output longint rx, ry, rz, inout bit ov);
        rx = clamp_word(qmul(py, qz, ov) - qmul(pz, qy, ov), ov);
        ry = clamp_word(qmul(pz, qx, ov) - qmul(px, qz, ov), ov);
        rz = clamp_word(qmul(px, qy, ov) - qmul(py, qx, ov), ov);
    endfunction

    function automatic rsp_t vec_alu_result(req_t q);
        longint ax, ay, az, bx, by, bz, s;
        longint k1, k2, k3, cx, cy, cz;
        longint rx, ry, rz, sc;
        bit     ov;
        rsp_t   o;
        ax = sx(q.a_x);
        ay = sx(q.a_y);
        az = sx(q.a_z);
        bx = sx(q.b_x);
        by = sx(q.b_y);
        bz = sx(q.b_z);
        s  = sx(q.scalar_in);
        rx = 0;
        ry = 0;
        rz = 0;
        sc = 0;
        ov = 1'b0;
        case (q.req_type)
            OP_ADD:
            begin
                rx = clamp_word(ax + bx, ov);
                ry = clamp_word(ay + by, ov);
                rz = clamp_word(az + bz, ov);
            end
            OP_SUB:
            begin
                rx = clamp_word(ax - bx, ov);
                ry = clamp_word(ay - by, ov);
                rz = clamp_word(az - bz, ov);
            end
            OP_SCALE:
            begin
                rx = qmul(ax, s, ov);
                ry = qmul(ay, s, ov);
                rz = qmul(az, s, ov);
            end
            OP_DOT:
                sc = dot3(ax, ay, az, bx, by, bz, ov);
            OP_CROSS:
                cross3(ax, ay, az, bx, by, bz, rx, ry, rz, ov);
            OP_ROT:
            begin
                // r = 2(b.a)b + (s*s - b.b)a + 2s(b x a), each stage saturated
                k1 = clamp_word(2 * dot3(bx, by, bz, ax, ay, az, ov), ov);
                k2 = clamp_word(qmul(s, s, ov) - dot3(bx, by, bz, bx, by, bz, ov), ov);
                k3 = clamp_word(2 * s, ov);
                cross3(bx, by, bz, ax, ay, az, cx, cy, cz, ov);
                rx = clamp_word(qmul(bx, k1, ov) + qmul(ax, k2, ov) + qmul(cx, k3, ov), ov);
                ry = clamp_word(qmul(by, k1, ov) + qmul(ay, k2, ov) + qmul(cy, k3, ov), ov);
                rz = clamp_word(qmul(bz, k1, ov) + qmul(az, k2, ov) + qmul(cz, k3, ov), ov);
            end
            default:
            begin
            end
        endcase
        o.r_x        = rx[DATA_WIDTH-1:0];
        o.r_y        = ry[DATA_WIDTH-1:0];
        o.r_z        = rz[DATA_WIDTH-1:0];
        o.scalar_out = sc[DATA_WIDTH-1:0];
        o.overflow   = ov;
        return o;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic rsp_t mk_rsp(fx_word_t x, fx_word_t y, fx_word_t z, fx_word_t sc,
                                    logic ov);
        rsp_t r;
        r.r_x        = x;
        r.r_y        = y;
        r.r_z        = z;
        r.scalar_out = sc;
        r.overflow   = ov;
        return r;
    endfunction

    function automatic void add_row(op_t op, fx_word_t ax, fx_word_t ay, fx_word_t az,
                                    fx_word_t bx, fx_word_t by, fx_word_t bz,
                                    fx_word_t s, bit fixed_exp, rsp_t e);
        vec_row_t row;
        row.q.req_type  = op;
        row.q.a_x       = ax;
        row.q.a_y       = ay;
        row.q.a_z       = az;
        row.q.b_x       = bx;
        row.q.b_y       = by;
        row.q.b_z       = bz;
        row.q.scalar_in = s;
        row.fixed_exp   = fixed_exp;
        row.exp_rsp     = e;
        plan.push_back(row);
    endfunction

    // Within +/-1.0, the range of a unit quaternion
    function automatic fx_word_t unit_frac();
        int v;
        v = $urandom_range(0, 2 * ONE);
        return v - ONE;
    endfunction

    function automatic fx_word_t rand_word();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                v = $urandom;
            4, 5, 6:
            begin
                v = $urandom_range(0, 32'h0010_0000);
                v = v - 32'sh0008_0000;
            end
            7, 8:
                v = unit_frac();
            default:
                case ($urandom_range(0, 5))
                    0:       v = FX_MAX;
                    1:       v = FX_MIN;
                    2:       v = 0;
                    3:       v = -1;
                    4:       v = 1;
                    default: v = ONE;
                endcase
        endcase
        return v;
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Entered at a falling edge; returns at a falling edge after the take and gap
    task automatic send_item(input req_t q, input bit fixed_exp, input rsp_t e,
                             input int gap);
        int seen;
        seen      = n_taken;
        req       = q;
        cur_fixed = fixed_exp;
        cur_exp   = e;
        start     = 1'b1;
        do
            @(negedge clk);
        while (n_taken == seen);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic flag(input string msg);
        n_err++;
        if (n_err <= REPORT_MAX)
            $display("%0t ns: %s", $time, msg);
    endtask

    // ---------------- monitor, checker and watchdog ----------------

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (start === 1'b1 && busy === 1'b0)
            begin
                rsp_due.push_back(cur_fixed ? cur_exp : vec_alu_result(req));
                n_taken++;
            end
            if (done === 1'b1)
            begin
                if (rsp_due.size() == 0)
                    flag($sformatf("result with no item outstanding: %h", rsp));
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp.r_x !== want.r_x)
                        flag($sformatf("r_x: expected %h, got %h", want.r_x, rsp.r_x));
                    if (rsp.r_y !== want.r_y)
                        flag($sformatf("r_y: expected %h, got %h", want.r_y, rsp.r_y));
                    if (rsp.r_z !== want.r_z)
                        flag($sformatf("r_z: expected %h, got %h", want.r_z, rsp.r_z));
                    if (rsp.scalar_out !== want.scalar_out)
                        flag($sformatf("scalar_out: expected %h, got %h",
                                       want.scalar_out, rsp.scalar_out));
                    if (rsp.overflow !== want.overflow)
                        flag($sformatf("overflow: expected %b, got %b",
                                       want.overflow, rsp.overflow));
                end
            end
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    initial
    begin
        int     i;
        int     r;
        int     gap;
        bit     burst;
        req_t   q;
        rsp_t   zero_rsp;
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cur_fixed = 1'b0;
        cur_exp   = '0;
        zero_rsp  = '0;
        burst     = 1'b0;

        // Add and subtract, including saturation at both rails
        add_row(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 1'b1, zero_rsp);
        add_row(OP_ADD, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 0, 1'b1,
                mk_rsp(FX_MAX, FX_MAX, FX_MAX, 0, 1'b1));
        add_row(OP_ADD, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, 0, 1'b1,
                mk_rsp(FX_MIN, FX_MIN, FX_MIN, 0, 1'b1));
        add_row(OP_SUB, FX_MIN, FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MAX, 0, 1'b1,
                mk_rsp(FX_MIN, FX_MIN, FX_MIN, 0, 1'b1));
        add_row(OP_SUB, FX_MAX, FX_MAX, FX_MAX, FX_MIN, FX_MIN, FX_MIN, 0, 1'b1,
                mk_rsp(FX_MAX, FX_MAX, FX_MAX, 0, 1'b1));
        add_row(OP_SUB, ONE, -1, 5, ONE, 1, -7, FX_MAX, 1'b0, zero_rsp);
        // Unknown codes give zero fields whatever the operands
        add_row(OP_SPARE6, -1, -1, -1, -1, -1, -1, -1, 1'b1, zero_rsp);
        add_row(OP_SPARE7, FX_MAX, FX_MIN, ONE, FX_MIN, FX_MAX, -1, FX_MIN, 1'b1, zero_rsp);
        // Scale
        add_row(OP_SCALE, 1, -1, FX_MAX, 0, 0, 0, ONE, 1'b1, mk_rsp(1, -1, FX_MAX, 0, 1'b0));
        add_row(OP_SCALE, FX_MAX, FX_MIN, -1, 0, 0, 0, FX_MAX, 1'b0, zero_rsp);
        add_row(OP_SCALE, FX_MIN, FX_MIN, FX_MIN, 0, 0, 0, FX_MIN, 1'b1,
                mk_rsp(FX_MAX, FX_MAX, FX_MAX, 0, 1'b1));
        add_row(OP_SCALE, -1, 1, 3, 0, 0, 0, HALF, 1'b0, zero_rsp);
        // Dot
        add_row(OP_DOT, ONE, 0, 0, ONE, 0, 0, 0, 1'b1, mk_rsp(0, 0, 0, ONE, 1'b0));
        add_row(OP_DOT, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 0, 1'b1,
                mk_rsp(0, 0, 0, FX_MAX, 1'b1));
        add_row(OP_DOT, FX_MIN, FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MAX, 0, 1'b0, zero_rsp);
        // Cross: x cross y is z, and z cross x is y (the sign-corrected term)
        add_row(OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0, 1'b1, mk_rsp(0, 0, ONE, 0, 1'b0));
        add_row(OP_CROSS, 0, 0, ONE, ONE, 0, 0, 0, 1'b1, mk_rsp(0, ONE, 0, 0, 1'b0));
        add_row(OP_CROSS, FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MIN, 0, 1'b0, zero_rsp);
        // Rotate: identity quaternion leaves the vector alone
        add_row(OP_ROT, 3 * ONE, -5 * ONE, 7 * ONE, 0, 0, 0, ONE, 1'b1,
                mk_rsp(3 * ONE, -5 * ONE, 7 * ONE, 0, 1'b0));
        add_row(OP_ROT, ONE, 0, 0, 0, 0, HALF_SQRT2, HALF_SQRT2, 1'b0, zero_rsp);
        add_row(OP_ROT, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b0, zero_rsp);
        add_row(OP_ROT, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b0, zero_rsp);
        // A real part of FX_MIN saturates both its double and its square
        add_row(OP_ROT, ONE, ONE, ONE, 0, 0, 0, FX_MIN, 1'b0, zero_rsp);

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[k])
            send_item(plan[k].q, plan[k].fixed_exp, plan[k].exp_rsp, rand_gap());

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            // Hold off until the pipeline has emptied
            if (i == RANDOM_ITEMS / 2)
            begin
                start = 1'b0;
                while (rsp_due.size() != 0)
                    @(negedge clk);
            end
            r = $urandom_range(0, 19);
            if (r < 18)
                q.req_type = op_t'(r % 6);
            else
                q.req_type = (r == 18) ? OP_SPARE6 : OP_SPARE7;
            q.a_x       = rand_word();
            q.a_y       = rand_word();
            q.a_z       = rand_word();
            q.b_x       = rand_word();
            q.b_y       = rand_word();
            q.b_z       = rand_word();
            q.scalar_in = rand_word();
            // Mostly parts within +/-1.0 for rotate, to keep more results in range
            if (q.req_type == OP_ROT && $urandom_range(0, 2) != 0)
            begin
                q.b_x       = unit_frac();
                q.b_y       = unit_frac();
                q.b_z       = unit_frac();
                q.scalar_in = unit_frac();
            end
            gap = burst ? 0 : rand_gap();
            send_item(q, 1'b0, zero_rsp, gap);
        end

        start = 1'b0;
        while (rsp_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (n_err == 0 && rsp_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
